// ----- rtl/ordered_list_engine_assert.svh -----
// Assertion macros used by the ordered list engine checker.
`ifndef ORDERED_LIST_ENGINE_ASSERT_SVH
`define ORDERED_LIST_ENGINE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define OLE_ASSERT_SAME(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("ordered list engine check failed");

// Next-cycle implication, sampled on clk, off during rst.
`define OLE_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("ordered list engine check failed");

`endif

// ----- rtl/ole_pkg.sv -----
// Shared constants, codes and types of the ordered list engine.
package ole_pkg;

  localparam int CAPACITY_DEF   = 16;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int OP_W   = 4;
  localparam int VAL_W  = 32;
  localparam int POS_W  = 5;
  localparam int FPOS_W = 4;
  localparam int LEN_W  = 5;

  localparam int S_OP_LSB  = 0;
  localparam int S_VAL_LSB = S_OP_LSB + OP_W;
  localparam int S_POS_LSB = S_VAL_LSB + VAL_W;
  localparam int S_TDATA_W = 48;

  localparam int M_STAT_LSB = 0;
  localparam int M_RD_LSB   = M_STAT_LSB + 1;
  localparam int M_FPOS_LSB = M_RD_LSB + VAL_W;
  localparam int M_LEN_LSB  = M_FPOS_LSB + FPOS_W;
  localparam int M_USED_W   = M_LEN_LSB + LEN_W;
  localparam int M_TDATA_W  = 48;
  localparam int M_PAD_W    = M_TDATA_W - M_USED_W;

  localparam logic [OP_W-1:0] OP_INS_FIRST = 4'd0;
  localparam logic [OP_W-1:0] OP_INS_LAST  = 4'd1;
  localparam logic [OP_W-1:0] OP_INS_AT    = 4'd2;
  localparam logic [OP_W-1:0] OP_DEL_FIRST = 4'd3;
  localparam logic [OP_W-1:0] OP_DEL_LAST  = 4'd4;
  localparam logic [OP_W-1:0] OP_DEL_AT    = 4'd5;
  localparam logic [OP_W-1:0] OP_READ      = 4'd6;
  localparam logic [OP_W-1:0] OP_FIND      = 4'd7;
  localparam logic [OP_W-1:0] OP_CLEAR     = 4'd8;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_START,
    CMD_STEP,
    CMD_OUT
  } cmd_t;

  typedef struct packed {
    logic quick;
    logic done;
  } dp_status_t;

endpackage

// ----- rtl/ole_ram.sv -----
// Simple dual-port RAM, one write port, one registered read port.
module ole_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/ole_ctrl.sv -----
// Controller: handshakes and sequencing of one operation at a time.
module ole_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  output logic                m_tvalid,
  input  logic                m_tready,
  output ole_pkg::cmd_t       cmd,
  input  ole_pkg::dp_status_t status
);
  import ole_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_WORK,
    S_FINISH
  } state_t;

  state_t state;
  logic   out_valid;
  logic   out_free;

  assign out_free = !out_valid || m_tready;
  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_valid;

  always_comb begin
    cmd = CMD_NONE;
    case (state)
      S_IDLE:   cmd = s_tvalid ? CMD_LOAD : CMD_NONE;
      S_DECODE: cmd = CMD_START;
      S_WORK:   cmd = CMD_STEP;
      S_FINISH: cmd = out_free ? CMD_OUT : CMD_NONE;
      default:  cmd = CMD_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == S_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          state <= status.quick ? S_FINISH : S_WORK;
        end
        S_WORK: begin
          if (status.done) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/ole_datapath.sv -----
// Datapath: operation registers, list storage, shift and scan pointers, results.
module ole_datapath #(
  parameter int CAPACITY   = ole_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = ole_pkg::DATA_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  ole_pkg::cmd_t                      cmd,
  output ole_pkg::dp_status_t                status,
  input  logic [ole_pkg::OP_W-1:0]           in_operation,
  input  logic signed [ole_pkg::VAL_W-1:0]   in_item_value,
  input  logic [ole_pkg::POS_W-1:0]          in_position,
  output logic                               out_status,
  output logic signed [ole_pkg::VAL_W-1:0]   out_read_value,
  output logic [ole_pkg::FPOS_W-1:0]         out_found_position,
  output logic [ole_pkg::LEN_W-1:0]          out_list_length
);
  import ole_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int LW = $clog2(CAPACITY + 1);
  localparam int CW = (LW > POS_W) ? LW : POS_W;

  typedef enum logic [2:0] {
    K_NONE,
    K_INS,
    K_DEL,
    K_READ,
    K_FIND,
    K_CLEAR
  } kind_t;

  logic [OP_W-1:0]        op_reg;
  logic [DATA_WIDTH-1:0]  data_reg;
  logic [POS_W-1:0]       pos_reg;
  kind_t                  kind_reg;
  logic [LW-1:0]          len;
  logic [LW-1:0]          idx;
  logic [LW-1:0]          tgt;
  logic                   pend;
  logic [AW-1:0]          pend_addr;
  logic                   res_status;
  logic signed [VAL_W-1:0] res_rd;
  logic [FPOS_W-1:0]      res_fpos;

  kind_t                  kind_dec;
  logic                   legal;
  logic [LW-1:0]          tgt_dec;
  logic [LW-1:0]          idx_dec;
  logic                   full;
  logic [CW-1:0]          lenx;
  logic [CW-1:0]          posx;

  logic                   step;
  logic                   step_done;
  logic                   hit;
  logic                   we;
  logic [AW-1:0]          waddr;
  logic [DATA_WIDTH-1:0]  wdata;
  logic                   re;
  logic [AW-1:0]          raddr;
  logic [DATA_WIDTH-1:0]  rdata;
  logic                   pend_next;
  logic [AW-1:0]          pend_addr_next;
  logic [LW-1:0]          idx_next;

  assign lenx = CW'(len);
  assign posx = CW'(pos_reg);
  assign full = (len == LW'(CAPACITY));
  assign step = (cmd == CMD_STEP);

  always_comb begin
    kind_dec = K_NONE;
    legal    = 1'b0;
    tgt_dec  = '0;
    idx_dec  = '0;
    case (op_reg)
      OP_INS_FIRST: begin
        kind_dec = K_INS;
        legal    = !full;
        idx_dec  = len;
      end
      OP_INS_LAST: begin
        kind_dec = K_INS;
        legal    = !full;
        tgt_dec  = len;
        idx_dec  = len;
      end
      OP_INS_AT: begin
        kind_dec = K_INS;
        legal    = !full && (posx <= lenx);
        tgt_dec  = LW'(pos_reg);
        idx_dec  = len;
      end
      OP_DEL_FIRST: begin
        kind_dec = K_DEL;
        legal    = (len != '0);
        idx_dec  = LW'(1);
      end
      OP_DEL_LAST: begin
        kind_dec = K_DEL;
        legal    = (len != '0);
        idx_dec  = len;
      end
      OP_DEL_AT: begin
        kind_dec = K_DEL;
        legal    = (posx < lenx);
        idx_dec  = LW'(pos_reg) + LW'(1);
      end
      OP_READ: begin
        kind_dec = K_READ;
        legal    = (posx < lenx);
      end
      OP_FIND: begin
        kind_dec = K_FIND;
        legal    = 1'b1;
      end
      OP_CLEAR: begin
        kind_dec = K_CLEAR;
        legal    = 1'b1;
      end
      default: begin
        kind_dec = K_NONE;
      end
    endcase
  end

  // Shifts run one entry per cycle: each moved word is read from the RAM and written to the address held in pend_addr.
  always_comb begin
    step_done      = 1'b0;
    hit            = 1'b0;
    we             = 1'b0;
    waddr          = pend_addr;
    wdata          = rdata;
    re             = 1'b0;
    raddr          = '0;
    pend_next      = pend;
    pend_addr_next = pend_addr;
    idx_next       = idx;
    case (kind_reg)
      K_INS: begin
        we = pend;
        if (idx > tgt) begin
          re             = 1'b1;
          raddr          = AW'(idx - LW'(1));
          pend_next      = 1'b1;
          pend_addr_next = AW'(idx);
          idx_next       = idx - LW'(1);
        end else begin
          pend_next = 1'b0;
          if (!pend) begin
            we        = 1'b1;
            waddr     = AW'(tgt);
            wdata     = data_reg;
            step_done = 1'b1;
          end
        end
      end
      K_DEL: begin
        we = pend;
        if (idx < len) begin
          re             = 1'b1;
          raddr          = AW'(idx);
          pend_next      = 1'b1;
          pend_addr_next = AW'(idx - LW'(1));
          idx_next       = idx + LW'(1);
        end else begin
          pend_next = 1'b0;
          step_done = !pend;
        end
      end
      K_FIND: begin
        hit = pend && (rdata == data_reg);
        if (hit) begin
          step_done = 1'b1;
        end else if (idx < len) begin
          re             = 1'b1;
          raddr          = AW'(idx);
          pend_next      = 1'b1;
          pend_addr_next = AW'(idx);
          idx_next       = idx + LW'(1);
        end else begin
          pend_next = 1'b0;
          step_done = !pend;
        end
      end
      K_READ: begin
        if (pend) begin
          step_done = 1'b1;
        end else begin
          re        = 1'b1;
          raddr     = AW'(pos_reg);
          pend_next = 1'b1;
        end
      end
      default: begin
        step_done = 1'b1;
      end
    endcase
  end

  assign status.quick = !legal || (kind_dec == K_CLEAR);
  assign status.done  = step_done;

  ole_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (we && step),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re && step),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      len  <= '0;
      pend <= 1'b0;
    end else begin
      case (cmd)
        CMD_START: begin
          pend <= 1'b0;
          if (kind_dec == K_CLEAR) begin
            len <= '0;
          end
        end
        CMD_STEP: begin
          pend <= pend_next;
          if (step_done && kind_reg == K_INS) begin
            len <= len + LW'(1);
          end else if (step_done && kind_reg == K_DEL) begin
            len <= len - LW'(1);
          end
        end
        default: begin
          pend <= pend;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd)
      CMD_LOAD: begin
        op_reg   <= in_operation;
        data_reg <= DATA_WIDTH'(in_item_value);
        pos_reg  <= in_position;
      end
      CMD_START: begin
        kind_reg   <= legal ? kind_dec : K_NONE;
        tgt        <= tgt_dec;
        idx        <= idx_dec;
        res_status <= !legal || (kind_dec == K_FIND);
        res_rd     <= (kind_dec == K_READ && !legal) ? '1 : '0;
        res_fpos   <= '0;
      end
      CMD_STEP: begin
        idx       <= idx_next;
        pend_addr <= pend_addr_next;
        if (hit) begin
          res_status <= 1'b0;
          res_fpos   <= FPOS_W'(pend_addr);
        end
        if (kind_reg == K_READ && pend) begin
          res_rd <= VAL_W'($signed(rdata));
        end
      end
      CMD_OUT: begin
        out_status         <= res_status;
        out_read_value     <= res_rd;
        out_found_position <= res_fpos;
        out_list_length    <= LEN_W'(len);
      end
      default: begin
        op_reg <= op_reg;
      end
    endcase
  end

endmodule

// ----- rtl/ordered_list_engine.sv -----
// Each transaction passes through decode, an optional work phase and finish before the result is valid.
// Work phase: insert and delete shift the entries behind the position, find scans the list,
// read fetches one entry; clear and rejected operations skip it.
// Only one operation is in flight; a new one is accepted once the result has been output.
// The shift and scan loop is bound by the single read and single write port of the RAM.
// Reset (rst, synchronous) empties the list; entry storage is not cleared.
module ordered_list_engine #(
  parameter int CAPACITY   = ole_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = ole_pkg::DATA_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // operation[3:0], item_value[35:4], position[40:36], zero fill
  input  logic [ole_pkg::S_TDATA_W-1:0]   s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // status[0], read_value[32:1], found_position[36:33], list_length[41:37], zero fill
  output logic [ole_pkg::M_TDATA_W-1:0]   m_tdata
);
  import ole_pkg::*;

  cmd_t                    cmd;
  dp_status_t              dp_status;
  logic                    res_status;
  logic signed [VAL_W-1:0] res_read_value;
  logic [FPOS_W-1:0]       res_found_position;
  logic [LEN_W-1:0]        res_list_length;

  ole_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .status   (dp_status)
  );

  ole_datapath #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .status             (dp_status),
    .in_operation       (s_tdata[S_OP_LSB +: OP_W]),
    .in_item_value      (s_tdata[S_VAL_LSB +: VAL_W]),
    .in_position        (s_tdata[S_POS_LSB +: POS_W]),
    .out_status         (res_status),
    .out_read_value     (res_read_value),
    .out_found_position (res_found_position),
    .out_list_length    (res_list_length)
  );

  assign m_tdata = {{M_PAD_W{1'b0}}, res_list_length, res_found_position,
                    res_read_value, res_status};

endmodule

// ----- rtl/ole_checker.sv -----
// Port-level checker of the ordered list engine and its bind.
`include "ordered_list_engine_assert.svh"

module ole_checker #(
  parameter int CAPACITY = ole_pkg::CAPACITY_DEF
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic [ole_pkg::S_TDATA_W-1:0] s_tdata,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [ole_pkg::M_TDATA_W-1:0] m_tdata
);
  import ole_pkg::*;

  logic              rsp_status;
  logic [VAL_W-1:0]  rsp_read_value;
  logic [FPOS_W-1:0] rsp_found_position;
  logic [LEN_W-1:0]  rsp_list_length;
  logic              req_seen;

  assign rsp_status         = m_tdata[M_STAT_LSB];
  assign rsp_read_value     = m_tdata[M_RD_LSB +: VAL_W];
  assign rsp_found_position = m_tdata[M_FPOS_LSB +: FPOS_W];
  assign rsp_list_length    = m_tdata[M_LEN_LSB +: LEN_W];
  assign req_seen           = s_tvalid && s_tready;

  `OLE_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `OLE_ASSERT_NEXT(a_one_in_flight, req_seen, !s_tready)
  `OLE_ASSERT_SAME(a_len_bound, m_tvalid, (CAPACITY > 31) || (int'(rsp_list_length) <= CAPACITY))
  `OLE_ASSERT_SAME(a_reject_read, m_tvalid && rsp_status && (rsp_read_value != '0), rsp_read_value == '1)
  `OLE_ASSERT_SAME(a_miss_pos, m_tvalid && rsp_status, rsp_found_position == '0)

endmodule

bind ordered_list_engine ole_checker #(
  .CAPACITY (CAPACITY)
) u_ole_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
